// ===== design/jked_pkg.sv =====
package jked_pkg;

  // event codes as reported on the result stream
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_UP     = 3'd1,
    EV_DOWN   = 3'd2,
    EV_LEFT   = 3'd3,
    EV_RIGHT  = 3'd4,
    EV_CLICK  = 3'd5,
    EV_DOUBLE = 3'd6,
    EV_LONG   = 3'd7
  } event_t;

  localparam int unsigned CFG_W = 16;

  typedef struct packed {
    logic   raise;
    event_t code;
  } ok_evt_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_DOUBLE   = 2'd2
  } reg_idx_t;

endpackage

// ===== design/jked_ok_fsm.sv =====
module jked_ok_fsm
  import jked_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             pin,
  input  logic [CFG_W-1:0] db_thr,
  input  logic [CFG_W-1:0] long_thr,
  input  logic [CFG_W-1:0] dbl_thr,
  output ok_evt_t          evt
);

  localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  typedef enum logic [2:0] {
    PH_WAIT     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_HELD     = 3'd2,
    PH_RELEASED = 3'd3,
    PH_LOCKOUT  = 3'd4
  } phase_t;

  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] tick_timer, tick_timer_next;
  logic [TIMER_BITS-1:0] timer_inc;
  logic [CMP_W-1:0]      timer_cmp;

  assign timer_inc = tick_timer + 1'b1;
  assign timer_cmp = CMP_W'(timer_inc);

  always_comb begin
    phase_next      = phase;
    tick_timer_next = timer_inc;
    evt.raise       = 1'b0;
    evt.code        = EV_NONE;
    unique case (phase)
      PH_WAIT: begin
        if (pin) begin
          tick_timer_next = '0;
          phase_next      = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        if (!pin) begin
          phase_next = PH_WAIT;
        end else if (timer_cmp >= CMP_W'(db_thr)) begin
          phase_next = PH_HELD;
        end
      end
      PH_HELD: begin
        if (!pin) begin
          phase_next      = PH_RELEASED;
          tick_timer_next = '0;
        end else if (timer_cmp >= CMP_W'(long_thr)) begin
          evt.raise  = 1'b1;
          evt.code   = EV_LONG;
          phase_next = PH_LOCKOUT;
        end
      end
      PH_RELEASED: begin
        // timeout wins over a second press in the same tick
        if (timer_cmp >= CMP_W'(dbl_thr)) begin
          evt.raise  = 1'b1;
          evt.code   = EV_CLICK;
          phase_next = PH_WAIT;
        end else if (pin) begin
          evt.raise  = 1'b1;
          evt.code   = EV_DOUBLE;
          phase_next = PH_LOCKOUT;
        end
      end
      PH_LOCKOUT: begin
        if (!pin) phase_next = PH_WAIT;
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_WAIT;
      tick_timer <= '0;
    end else if (step) begin
      phase      <= phase_next;
      tick_timer <= tick_timer_next;
    end
  end

endmodule

// ===== design/joystick_key_event_detector_unit.sv =====
// pipeline: input transaction to result through the input register and the result register
// throughput: one item per cycle while the result stream is not stalled; the direction compares
// and the ok-key timer compare sit between the input register and the result register
// reset: synchronous, active high; registers return to 2 / 100 / 30, direction,
// ok-key phase, tick timer and pending event clear, both stages empty
module joystick_key_event_detector_unit
  import jked_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // [11:0] adc_sample, [12] ok_level, [13] take_event, [15:14] zero
  input  logic [15:0]      s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [2:0] pending_event, [7:3] zero
  output logic [7:0]       m_axis_tdata,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam logic [11:0] LEFT_ABOVE = 12'd3800;
  localparam logic [11:0] RIGHT_LO   = 12'd1900;
  localparam logic [11:0] RIGHT_HI   = 12'd2200;
  localparam logic [11:0] UP_LO      = 12'd900;
  localparam logic [11:0] UP_HI      = 12'd1200;
  localparam logic [11:0] DOWN_LO    = 12'd1250;
  localparam logic [11:0] DOWN_HI    = 12'd1550;

  function automatic event_t classify(input logic [11:0] s);
    event_t d;
    if (s > LEFT_ABOVE)                      d = EV_LEFT;
    else if (s > RIGHT_LO && s < RIGHT_HI)   d = EV_RIGHT;
    else if (s > UP_LO && s < UP_HI)         d = EV_UP;
    else if (s > DOWN_LO && s < DOWN_HI)     d = EV_DOWN;
    else                                     d = EV_NONE;
    return d;
  endfunction

  logic [CFG_W-1:0] db_thr, long_thr, dbl_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      db_thr   <= CFG_W'(2);
      long_thr <= CFG_W'(100);
      dbl_thr  <= CFG_W'(30);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: db_thr   <= cfg_wdata;
        REG_LONG:     long_thr <= cfg_wdata;
        REG_DOUBLE:   dbl_thr  <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // input register
  logic        s1_valid;
  logic [11:0] s1_sample;
  logic        s1_pin;
  logic        s1_take;
  logic        s1_adv;

  assign s1_adv        = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      s1_sample <= s_axis_tdata[11:0];
      s1_pin    <= s_axis_tdata[12];
      s1_take   <= s_axis_tdata[13];
    end
  end

  ok_evt_t ok_evt;

  jked_ok_fsm #(
    .TIMER_BITS(TIMER_BITS)
  ) u_ok_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_adv),
    .pin     (s1_pin),
    .db_thr  (db_thr),
    .long_thr(long_thr),
    .dbl_thr (dbl_thr),
    .evt     (ok_evt)
  );

  event_t last_direction;
  event_t latched_event, latched_event_next;
  event_t dir;
  event_t report;

  always_comb begin
    dir    = classify(s1_sample);
    report = latched_event;
    // press is only seen on a change from none to a direction
    if (last_direction == EV_NONE && dir != EV_NONE) report = dir;
    if (ok_evt.raise) report = ok_evt.code;
    latched_event_next = s1_take ? EV_NONE : report;
  end

  event_t out_event;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_direction <= EV_NONE;
      latched_event  <= EV_NONE;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (s1_adv) begin
        last_direction <= dir;
        latched_event  <= latched_event_next;
        m_axis_tvalid  <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (s1_adv) out_event <= report;
  end

  assign m_axis_tdata = {5'd0, out_event};

  a_take_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_take) |=> (latched_event == EV_NONE))
    else $error("pending event not cleared after take");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> m_axis_tvalid)
    else $error("result register not loaded after stage advance");

  a_dir_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(last_direction) && $stable(latched_event))
    else $error("event state changed without a stage advance");

  a_stall_no_adv: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s1_adv)
    else $error("stage advanced into a stalled result register");

endmodule
